@@ hw/rtl/cba_pkg.sv @@
// Package for the cluster bitmap allocator: request/result structs,
// operation, status and controller state codes, shared constants.
// No dependencies.
package cba_pkg;

  localparam int MAX_CLUSTERS_DEF  = 65536;
  // clusters are 16-bit numbers, so no more than this many entries matter
  localparam int CLUSTER_SPACE     = 65536;
  localparam int COUNT_W           = 17;
  localparam int CLUSTER_W         = 16;
  localparam int LINK_W            = 32;
  localparam logic [COUNT_W-1:0] COUNT_RST  = 17'd65536;
  localparam logic [LINK_W-1:0]  END_MARK   = 32'hFFFF_FFFF;
  localparam logic [COUNT_W-1:0] FIRST_DATA = 17'd2;

  typedef enum logic [1:0] {
    OP_ALLOC  = 2'd0,
    OP_FREE   = 2'd1,
    OP_LINK   = 2'd2,
    OP_EXTEND = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_FULL  = 2'd1,
    STAT_RANGE = 2'd2,
    STAT_LOOP  = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_FREE_WALK,
    S_EXT_WALK,
    S_SCAN,
    S_LINK_TAIL
  } state_t;

  typedef struct packed {
    op_t                   op;
    logic [CLUSTER_W-1:0]  cluster;
    logic [LINK_W-1:0]     fat_value;
  } in_req_t;

  typedef struct packed {
    status_t               status;
    logic [CLUSTER_W-1:0]  result_cluster;
  } out_res_t;

endpackage

@@ hw/rtl/cba_ram.sv @@
// Single-port-write, single-port-read synchronous RAM with registered read
// data and write-first bypass on an address match. Used for the bitmap words
// and the link table. No package dependencies.
module cba_ram #(
  parameter int DATA_W = 32,
  parameter int ADDR_W = 16
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [DATA_W-1:0] wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [2**ADDR_W];
  logic [DATA_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // forward a same-cycle write so a read-modify-write chain sees its own update
  always_ff @(posedge clk) begin
    if (we && (waddr == raddr)) begin
      rdata_r <= wdata;
    end else begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

@@ hw/rtl/cba_find.sv @@
// Lowest-free-cluster finder over one bitmap word; clusters below 2 and not
// below the effective count are excluded. Depends on cba_pkg.
module cba_find #(
  parameter int WBW = 5,
  parameter int WAW = 11
) (
  input  logic [2**WBW-1:0]           word,
  input  logic [WAW-1:0]              word_idx,
  input  logic [cba_pkg::COUNT_W-1:0] n_eff,
  output logic                        hit,
  output logic [WBW-1:0]              bit_idx
);

  localparam int WB = 2**WBW;

  logic [WB-1:0] free_mask;

  always_comb begin
    logic [cba_pkg::COUNT_W-1:0] c;
    for (int j = 0; j < WB; j++) begin
      c = cba_pkg::COUNT_W'({word_idx, WBW'(j)});
      free_mask[j] = !word[j] && (c >= cba_pkg::FIRST_DATA) && (c < n_eff);
    end
  end

  always_comb begin
    bit_idx = '0;
    for (int j = WB - 1; j >= 0; j--) begin
      if (free_mask[j]) begin
        bit_idx = WBW'(j);
      end
    end
  end

  assign hit = |free_mask;

endmodule

@@ hw/rtl/cluster_bitmap_allocator.sv @@
// Cluster bitmap allocator top level: controller, bitmap word RAM, link RAM.
// Depends on cba_pkg, cba_ram and cba_find.
//
//  channel | ports                          | handshake
//  --------+--------------------------------+-------------------------------
//  request | start, busy, in_data           | taken when start && !busy
//  result  | out_strobe, out_data           | one-cycle strobe, no stall
//  config  | cfg_valid, cfg_ready, cfg_data | written when valid && ready
//
// After reset a clearing pass writes one link entry and bitmap word a cycle over
// all 2**clog2(min(MAX_CLUSTERS,65536)) link entries (65536 by default) with busy
// high. Link writes and refused requests strobe the cycle after the accept. Free
// and extend walk one chain entry a cycle; a scan reads one bitmap word (32 bits;
// 8 below 64 clusters) a cycle through the registered RAM read, and extend then
// links the tail in its own state. Config waits for idle; results cannot be stalled.
module cluster_bitmap_allocator #(
  parameter int MAX_CLUSTERS = cba_pkg::MAX_CLUSTERS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  output logic                        busy,
  input  cba_pkg::in_req_t            in_data,
  output logic                        out_strobe,
  output cba_pkg::out_res_t           out_data,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [cba_pkg::COUNT_W-1:0] cfg_data
);

  localparam int DEPTH = (MAX_CLUSTERS > cba_pkg::CLUSTER_SPACE) ?
                         cba_pkg::CLUSTER_SPACE : MAX_CLUSTERS;
  localparam int CW    = $clog2(DEPTH);
  localparam int WB    = (DEPTH >= 64) ? 32 : 8;
  localparam int WBW   = $clog2(WB);
  localparam int WAW   = CW - WBW;
  localparam logic [cba_pkg::COUNT_W-1:0] DEPTH_N = cba_pkg::COUNT_W'(DEPTH);

  cba_pkg::state_t                    state_r, state_nxt;
  cba_pkg::op_t                       op_r, op_nxt;
  logic [cba_pkg::CLUSTER_W-1:0]      cur_r, cur_nxt;
  logic [cba_pkg::CLUSTER_W-1:0]      nc_r, nc_nxt;
  logic [cba_pkg::COUNT_W-1:0]        visited_r, visited_nxt;
  logic [WAW-1:0]                     scan_addr_r, scan_addr_nxt;
  logic [WAW-1:0]                     rd_word_r, rd_word_nxt;
  logic                               rd_valid_r, rd_valid_nxt;
  logic [CW-1:0]                      clr_cnt_r, clr_cnt_nxt;
  logic [cba_pkg::COUNT_W-1:0]        count_r;
  logic                               out_strobe_r, out_strobe_nxt;
  cba_pkg::out_res_t                  out_data_r, out_data_nxt;

  logic                               bm_we;
  logic [WAW-1:0]                     bm_waddr, bm_raddr;
  logic [WB-1:0]                      bm_wdata, bm_rdata;
  logic                               ln_we;
  logic [CW-1:0]                      ln_waddr, ln_raddr;
  logic [cba_pkg::LINK_W-1:0]         ln_wdata, ln_rdata;

  logic [cba_pkg::COUNT_W-1:0]        n_eff, n_m1, limit;
  logic [WAW-1:0]                     last_word;
  logic [cba_pkg::COUNT_W-1:0]        in_cl;
  logic                               accept, in_range, in_data_cl, n_alloc_ok;
  logic                               next_is_link, walk_loop;
  logic                               hit;
  logic [WBW-1:0]                     hit_bit;
  logic [CW-1:0]                      found_cl;

  // ---------------------------------------------------------------- storage
  cba_ram #(.DATA_W(WB), .ADDR_W(WAW)) u_bitmap (
    .clk   (clk),
    .we    (bm_we),
    .waddr (bm_waddr),
    .wdata (bm_wdata),
    .raddr (bm_raddr),
    .rdata (bm_rdata)
  );

  cba_ram #(.DATA_W(cba_pkg::LINK_W), .ADDR_W(CW)) u_link (
    .clk   (clk),
    .we    (ln_we),
    .waddr (ln_waddr),
    .wdata (ln_wdata),
    .raddr (ln_raddr),
    .rdata (ln_rdata)
  );

  cba_find #(.WBW(WBW), .WAW(WAW)) u_find (
    .word     (bm_rdata),
    .word_idx (rd_word_r),
    .n_eff    (n_eff),
    .hit      (hit),
    .bit_idx  (hit_bit)
  );

  // ------------------------------------------------------- shared decisions
  assign n_eff      = (count_r > DEPTH_N) ? DEPTH_N : count_r;
  assign n_m1       = n_eff - 1'b1;
  assign last_word  = n_m1[CW-1:WBW];
  assign limit      = (n_eff > cba_pkg::FIRST_DATA) ? (n_eff - cba_pkg::FIRST_DATA) : '0;
  assign n_alloc_ok = n_eff > cba_pkg::FIRST_DATA;

  assign busy       = (state_r != cba_pkg::S_IDLE);
  assign accept     = start && !busy;
  assign in_cl      = cba_pkg::COUNT_W'(in_data.cluster);
  assign in_range   = in_cl < n_eff;
  assign in_data_cl = in_range && (in_cl >= cba_pkg::FIRST_DATA);

  assign next_is_link = (ln_rdata >= cba_pkg::LINK_W'(cba_pkg::FIRST_DATA)) &&
                        (ln_rdata <  cba_pkg::LINK_W'(n_eff));
  assign walk_loop    = next_is_link && (visited_r >= limit);
  assign found_cl     = {rd_word_r, hit_bit};

  // ----------------------------------------------------------- next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      cba_pkg::S_CLEAR: begin
        if (clr_cnt_r == '1) state_nxt = cba_pkg::S_IDLE;
      end
      cba_pkg::S_IDLE: begin
        if (accept) begin
          unique case (in_data.op)
            cba_pkg::OP_ALLOC:  if (n_alloc_ok) state_nxt = cba_pkg::S_SCAN;
            cba_pkg::OP_FREE:   if (in_data_cl) state_nxt = cba_pkg::S_FREE_WALK;
            cba_pkg::OP_LINK:   state_nxt = cba_pkg::S_IDLE;
            cba_pkg::OP_EXTEND: if (in_data_cl) state_nxt = cba_pkg::S_EXT_WALK;
          endcase
        end
      end
      cba_pkg::S_FREE_WALK: begin
        if (!next_is_link || walk_loop) state_nxt = cba_pkg::S_IDLE;
      end
      cba_pkg::S_EXT_WALK: begin
        if (!next_is_link)  state_nxt = cba_pkg::S_SCAN;
        else if (walk_loop) state_nxt = cba_pkg::S_IDLE;
      end
      cba_pkg::S_SCAN: begin
        if (rd_valid_r) begin
          if (hit) begin
            state_nxt = (op_r == cba_pkg::OP_EXTEND) ? cba_pkg::S_LINK_TAIL
                                                      : cba_pkg::S_IDLE;
          end else if (rd_word_r == last_word) begin
            state_nxt = cba_pkg::S_IDLE;
          end
        end
      end
      cba_pkg::S_LINK_TAIL: state_nxt = cba_pkg::S_IDLE;
      default:              state_nxt = cba_pkg::S_IDLE;
    endcase
  end

  // ------------------------------------------------- datapath and memories
  always_comb begin
    op_nxt         = op_r;
    cur_nxt        = cur_r;
    nc_nxt         = nc_r;
    visited_nxt    = visited_r;
    scan_addr_nxt  = scan_addr_r;
    rd_word_nxt    = rd_word_r;
    rd_valid_nxt   = 1'b0;
    clr_cnt_nxt    = clr_cnt_r;
    out_strobe_nxt = 1'b0;
    out_data_nxt   = '{status: cba_pkg::STAT_OK, result_cluster: '0};

    bm_we    = 1'b0;
    bm_waddr = cur_r[CW-1:WBW];
    bm_wdata = bm_rdata;
    bm_raddr = in_data.cluster[CW-1:WBW];
    ln_we    = 1'b0;
    ln_waddr = in_data.cluster[CW-1:0];
    ln_wdata = in_data.fat_value;
    ln_raddr = in_data.cluster[CW-1:0];

    unique case (state_r)
      cba_pkg::S_CLEAR: begin
        bm_we       = 1'b1;
        bm_waddr    = clr_cnt_r[WAW-1:0];
        bm_wdata    = '0;
        ln_we       = 1'b1;
        ln_waddr    = clr_cnt_r;
        ln_wdata    = '0;
        clr_cnt_nxt = clr_cnt_r + 1'b1;
      end

      cba_pkg::S_IDLE: begin
        // reads toward the request's cluster are already issued above
        if (accept) begin
          op_nxt        = in_data.op;
          cur_nxt       = in_data.cluster;
          visited_nxt   = cba_pkg::COUNT_W'(1);
          scan_addr_nxt = '0;
          unique case (in_data.op)
            cba_pkg::OP_ALLOC: begin
              if (!n_alloc_ok) begin
                out_strobe_nxt      = 1'b1;
                out_data_nxt.status = cba_pkg::STAT_FULL;
              end
            end
            cba_pkg::OP_FREE: begin
              if (!in_range && (in_cl >= cba_pkg::FIRST_DATA)) begin
                out_strobe_nxt      = 1'b1;
                out_data_nxt.status = cba_pkg::STAT_RANGE;
              end else if (!in_data_cl) begin
                out_strobe_nxt = 1'b1;
              end
            end
            cba_pkg::OP_LINK: begin
              out_strobe_nxt = 1'b1;
              if (in_range) ln_we = 1'b1;
              else          out_data_nxt.status = cba_pkg::STAT_RANGE;
            end
            cba_pkg::OP_EXTEND: begin
              if (!in_data_cl) begin
                out_strobe_nxt      = 1'b1;
                out_data_nxt.status = cba_pkg::STAT_RANGE;
              end
            end
          endcase
        end
      end

      cba_pkg::S_FREE_WALK: begin
        // clear this cluster's bit; the RAM forwards it if the next read hits
        bm_we    = 1'b1;
        bm_wdata = bm_rdata & ~(WB'(1) << cur_r[WBW-1:0]);
        ln_raddr = ln_rdata[CW-1:0];
        bm_raddr = ln_rdata[CW-1:WBW];
        if (!next_is_link) begin
          out_strobe_nxt = 1'b1;
        end else if (walk_loop) begin
          out_strobe_nxt      = 1'b1;
          out_data_nxt.status = cba_pkg::STAT_LOOP;
        end else begin
          cur_nxt     = ln_rdata[cba_pkg::CLUSTER_W-1:0];
          visited_nxt = visited_r + 1'b1;
        end
      end

      cba_pkg::S_EXT_WALK: begin
        ln_raddr = ln_rdata[CW-1:0];
        if (next_is_link) begin
          if (walk_loop) begin
            out_strobe_nxt      = 1'b1;
            out_data_nxt.status = cba_pkg::STAT_LOOP;
          end else begin
            cur_nxt     = ln_rdata[cba_pkg::CLUSTER_W-1:0];
            visited_nxt = visited_r + 1'b1;
          end
        end
      end

      cba_pkg::S_SCAN: begin
        bm_raddr      = scan_addr_r;
        scan_addr_nxt = scan_addr_r + 1'b1;
        rd_word_nxt   = scan_addr_r;
        rd_valid_nxt  = 1'b1;
        if (rd_valid_r) begin
          if (hit) begin
            rd_valid_nxt = 1'b0;
            bm_we        = 1'b1;
            bm_waddr     = rd_word_r;
            bm_wdata     = bm_rdata | (WB'(1) << hit_bit);
            nc_nxt       = cba_pkg::CLUSTER_W'(found_cl);
            if (op_r == cba_pkg::OP_EXTEND) begin
              ln_we    = 1'b1;
              ln_waddr = found_cl;
              ln_wdata = cba_pkg::END_MARK;
            end else begin
              out_strobe_nxt              = 1'b1;
              out_data_nxt.result_cluster = cba_pkg::CLUSTER_W'(found_cl);
            end
          end else if (rd_word_r == last_word) begin
            rd_valid_nxt        = 1'b0;
            out_strobe_nxt      = 1'b1;
            out_data_nxt.status = cba_pkg::STAT_FULL;
          end
        end
      end

      cba_pkg::S_LINK_TAIL: begin
        ln_we                       = 1'b1;
        ln_waddr                    = cur_r[CW-1:0];
        ln_wdata                    = cba_pkg::LINK_W'(nc_r);
        out_strobe_nxt              = 1'b1;
        out_data_nxt.result_cluster = nc_r;
      end

      default: begin
        out_strobe_nxt = 1'b0;
      end
    endcase
  end

  // -------------------------------------------------------------- registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= cba_pkg::S_CLEAR;
      clr_cnt_r    <= '0;
      rd_valid_r   <= 1'b0;
      out_strobe_r <= 1'b0;
      count_r      <= cba_pkg::COUNT_RST;
    end else begin
      state_r      <= state_nxt;
      clr_cnt_r    <= clr_cnt_nxt;
      rd_valid_r   <= rd_valid_nxt;
      out_strobe_r <= out_strobe_nxt;
      if (cfg_valid && cfg_ready) count_r <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    op_r        <= op_nxt;
    cur_r       <= cur_nxt;
    nc_r        <= nc_nxt;
    visited_r   <= visited_nxt;
    scan_addr_r <= scan_addr_nxt;
    rd_word_r   <= rd_word_nxt;
    out_data_r  <= out_data_nxt;
  end

  // hold the count while a request is in flight or being taken
  assign cfg_ready  = !busy && !start;
  assign out_strobe = out_strobe_r;
  assign out_data   = out_data_r;

  // ------------------------------------------------------------- assertions
  a_accept_progress: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> (out_strobe || busy))
    else $error("request neither answered nor in progress");

  a_idle_return_strobes: assert property (@(posedge clk) disable iff (!rst_n)
    ($fell(busy) && ($past(state_r) != cba_pkg::S_CLEAR)) |-> out_strobe)
    else $error("controller went idle without a result");

  a_error_no_cluster: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && (out_data.status != cba_pkg::STAT_OK)) |->
      (out_data.result_cluster == '0))
    else $error("error result carries a cluster number");

  a_alloc_not_reserved: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && (out_data.result_cluster != '0)) |->
      (out_data.result_cluster >= cba_pkg::CLUSTER_W'(cba_pkg::FIRST_DATA)))
    else $error("reserved cluster handed out");

endmodule
